/* rtl/rtcsm_pkg.sv */
// Shared constants and types for the three-wire RTC serial master.
package rtcsm_pkg;

  localparam int BURST_BYTES = 8;
  localparam int BURST_N = (BURST_BYTES < 1) ? 1 : ((BURST_BYTES > 8) ? 8 : BURST_BYTES);
  localparam logic [3:0] BURST_COUNT = 4'(BURST_N);

  localparam logic [7:0] BURST_CMD_RESET = 8'd190;

  localparam int MODE_READ_BIT  = 0;
  localparam int MODE_BURST_BIT = 1;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  localparam int IN_START_BIT = 0;
  localparam int IN_MODE_LO   = 1;
  localparam int IN_CMD_LO    = 3;
  localparam int IN_WDATA_LO  = 11;
  localparam int IN_DIN_BIT   = 75;
  localparam int IN_USED_W    = 76;

  localparam int OUT_CE_BIT    = 0;
  localparam int OUT_SCLK_BIT  = 1;
  localparam int OUT_DOUT_BIT  = 2;
  localparam int OUT_DRIVE_BIT = 3;
  localparam int OUT_RDATA_LO  = 4;
  localparam int OUT_BUSY_BIT  = 68;
  localparam int OUT_DONE_BIT  = 69;
  localparam int OUT_USED_W    = 70;

  typedef struct packed {
    logic        start_req;
    logic [1:0]  mode;
    logic [7:0]  command_byte;
    logic [63:0] write_data;
    logic        dat_in;
  } rtcsm_in_t;

  typedef struct packed {
    logic        ce_pin;
    logic        sclk_pin;
    logic        dat_out;
    logic        dat_drive;
    logic [63:0] read_data;
    logic        busy_res;
    logic        done_res;
  } rtcsm_res_t;

endpackage

/* rtl/rtcsm_seq.sv */
// Bus tick sequencer: transaction state and the pin pattern for each tick.
module rtcsm_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            burst_command,
  input  rtcsm_pkg::rtcsm_in_t  tick,
  output rtcsm_pkg::rtcsm_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WLOW  = 3'd1,
    PH_WHIGH = 3'd2,
    PH_RLOW  = 3'd3,
    PH_RHIGH = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [1:0]  held_mode, held_mode_next;
  logic [63:0] send_buffer, send_buffer_next;
  logic [63:0] receive_buffer, receive_buffer_next;

  logic        was_read;
  logic [7:0]  shifted;
  logic [2:0]  bit_inc;
  logic [3:0]  byte_inc;
  logic [2:0]  store_lane;
  logic [2:0]  load_lane;
  logic [3:0]  data_bytes;
  logic [7:0]  start_cmd;

  assign was_read   = (phase == PH_RHIGH);
  assign shifted    = was_read ? shift_register : {1'b0, shift_register[7:1]};
  assign bit_inc    = bit_index + 3'd1;
  assign byte_inc   = byte_index + 4'd1;
  assign store_lane = 3'(byte_index - 4'd1);
  assign load_lane  = 3'(byte_inc - 4'd1);
  assign data_bytes = held_mode[rtcsm_pkg::MODE_BURST_BIT] ? rtcsm_pkg::BURST_COUNT : 4'd1;
  assign start_cmd  = (tick.mode[rtcsm_pkg::MODE_BURST_BIT] ? burst_command : tick.command_byte)
                      | {7'd0, tick.mode[rtcsm_pkg::MODE_READ_BIT]};

  always_comb begin
    phase_next          = phase;
    shift_register_next = shift_register;
    bit_index_next      = bit_index;
    byte_index_next     = byte_index;
    held_mode_next      = held_mode;
    send_buffer_next    = send_buffer;
    receive_buffer_next = receive_buffer;
    res                 = '0;
    unique case (phase)
      PH_WLOW: begin
        phase_next   = PH_WHIGH;
        res.ce_pin   = 1'b1;
        res.sclk_pin = 1'b1;
        res.dat_out  = shift_register[0];
        res.dat_drive = 1'b1;
        res.busy_res = 1'b1;
      end
      PH_RLOW: begin
        phase_next   = PH_RHIGH;
        res.ce_pin   = 1'b1;
        res.sclk_pin = 1'b1;
        res.busy_res = 1'b1;
      end
      PH_WHIGH, PH_RHIGH: begin
        bit_index_next      = bit_inc;
        shift_register_next = shifted;
        if (bit_inc != 3'd0) begin
          res.ce_pin   = 1'b1;
          res.busy_res = 1'b1;
          if (was_read) begin
            shift_register_next = {tick.dat_in, shifted[7:1]};
            phase_next          = PH_RLOW;
          end else begin
            phase_next    = PH_WLOW;
            res.dat_out   = shifted[0];
            res.dat_drive = 1'b1;
          end
        end else begin
          if (was_read && byte_index != 4'd0) begin
            receive_buffer_next[8*store_lane +: 8] = receive_buffer[8*store_lane +: 8] | shifted;
          end
          byte_index_next = byte_inc;
          if (byte_inc > data_bytes) begin
            phase_next   = PH_IDLE;
            res.done_res = 1'b1;
          end else if (held_mode[rtcsm_pkg::MODE_READ_BIT]) begin
            shift_register_next = {tick.dat_in, 7'd0};
            phase_next          = PH_RLOW;
            res.ce_pin          = 1'b1;
            res.busy_res        = 1'b1;
          end else begin
            shift_register_next = send_buffer[8*load_lane +: 8];
            phase_next          = PH_WLOW;
            res.ce_pin          = 1'b1;
            res.busy_res        = 1'b1;
            res.dat_out         = send_buffer[8*load_lane];
            res.dat_drive       = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (tick.start_req) begin
          held_mode_next      = tick.mode;
          send_buffer_next    = tick.write_data;
          if (tick.mode[rtcsm_pkg::MODE_READ_BIT]) begin
            receive_buffer_next = '0;
          end
          shift_register_next = start_cmd;
          bit_index_next      = 3'd0;
          byte_index_next     = 4'd0;
          phase_next          = PH_WLOW;
          res.ce_pin          = 1'b1;
          res.dat_out         = start_cmd[0];
          res.dat_drive       = 1'b1;
          res.busy_res        = 1'b1;
        end
      end
    endcase
    res.read_data = receive_buffer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      shift_register <= '0;
      bit_index      <= '0;
      byte_index     <= '0;
      held_mode      <= '0;
      send_buffer    <= '0;
      receive_buffer <= '0;
    end else if (step) begin
      phase          <= phase_next;
      shift_register <= shift_register_next;
      bit_index      <= bit_index_next;
      byte_index     <= byte_index_next;
      held_mode      <= held_mode_next;
      send_buffer    <= send_buffer_next;
      receive_buffer <= receive_buffer_next;
    end
  end

endmodule

/* rtl/three_wire_rtc_serial_master.sv */
// Top level of the three-wire RTC serial master: stream stages and configuration.
// Each request on the input stream is one bus tick and yields exactly one result, the pin
// levels and status for that tick. A request is taken in every cycle unless the output side
// stalls; it passes an input register, one pass through the tick sequencer and a result
// register, and a stalled output side holds the result in that register.
// A single-byte transfer spans 33 requests from the start tick to the done tick, and a burst
// spans 16 * (1 + BURST_BYTES) + 1 requests. The burst command register may be written on the
// configuration channel, which is always ready, while no transaction is in flight.
module three_wire_rtc_serial_master (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_req, mode, command_byte, write_data, dat_in, zero fill
  input  logic [rtcsm_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // ce_pin, sclk_pin, dat_out, dat_drive, read_data, busy_res, done_res, zero fill
  output logic [rtcsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_data
);

  rtcsm_pkg::rtcsm_in_t  in_fields;
  rtcsm_pkg::rtcsm_in_t  in_reg;
  rtcsm_pkg::rtcsm_res_t res;
  logic                  in_valid;
  logic                  move;
  logic [7:0]            burst_command;
  logic [rtcsm_pkg::OUT_TDATA_W-1:0] out_data;
  logic                  out_valid;

  assign in_fields.start_req    = s_tdata[rtcsm_pkg::IN_START_BIT];
  assign in_fields.mode         = s_tdata[rtcsm_pkg::IN_MODE_LO +: 2];
  assign in_fields.command_byte = s_tdata[rtcsm_pkg::IN_CMD_LO +: 8];
  assign in_fields.write_data   = s_tdata[rtcsm_pkg::IN_WDATA_LO +: 64];
  assign in_fields.dat_in       = s_tdata[rtcsm_pkg::IN_DIN_BIT];

  assign move      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || move;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_command <= rtcsm_pkg::BURST_CMD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      burst_command <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_reg <= in_fields;
    end
  end

  rtcsm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .step          (move),
    .burst_command (burst_command),
    .tick          (in_reg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (move) begin
      out_data <= {{(rtcsm_pkg::OUT_TDATA_W - rtcsm_pkg::OUT_USED_W){1'b0}},
                   res.done_res, res.busy_res, res.read_data,
                   res.dat_drive, res.dat_out, res.sclk_pin, res.ce_pin};
    end
  end

endmodule

/* rtl/rtcsm_checker.sv */
// Port-level checks for the three-wire RTC serial master, bound to the top level.
module rtcsm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rtcsm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or was dropped.");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[rtcsm_pkg::OUT_DONE_BIT] |->
      !m_tdata[rtcsm_pkg::OUT_CE_BIT] && !m_tdata[rtcsm_pkg::OUT_BUSY_BIT])
    else $error("Done tick with chip enable or busy still high.");

  a_dout_driven: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[rtcsm_pkg::OUT_DOUT_BIT] |-> m_tdata[rtcsm_pkg::OUT_DRIVE_BIT])
    else $error("Data level high while the data line is released.");

  a_sclk_in_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[rtcsm_pkg::OUT_SCLK_BIT] |->
      m_tdata[rtcsm_pkg::OUT_CE_BIT] && m_tdata[rtcsm_pkg::OUT_BUSY_BIT])
    else $error("Serial clock high outside a transaction.");

endmodule

bind three_wire_rtc_serial_master rtcsm_checker u_rtcsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/three_wire_rtc_serial_master_tb.sv */
// Self-checking testbench for the three-wire RTC serial master with a tick-level predictor.
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_tb;

  localparam logic [1:0] MODE_SINGLE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SINGLE_READ  = 2'd1;
  localparam logic [1:0] MODE_BURST_WRITE  = 2'd2;
  localparam logic [1:0] MODE_BURST_READ   = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_REQUESTS = 560;

  typedef enum logic [2:0] {SEQ_IDLE, SEQ_WLOW, SEQ_WHIGH, SEQ_RLOW, SEQ_RHIGH} seq_phase_t;
  typedef enum int {DIN_LOW, DIN_HIGH, DIN_RANDOM} din_src_t;
  typedef enum int {FILL_IDLE, FILL_START, FILL_RANDOM} busy_fill_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [rtcsm_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                              m_tvalid;
  logic                              m_tready = 1'b1;
  logic [rtcsm_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [7:0]                        cfg_data;

  seq_phase_t  seq_phase;
  logic [7:0]  shifter;
  logic [7:0]  burst_cmd;
  logic [2:0]  bit_cnt;
  logic [3:0]  byte_cnt;
  logic [1:0]  cur_mode;
  logic [63:0] tx_bytes;
  logic [63:0] rx_bytes;
  rtcsm_pkg::rtcsm_res_t pin_expect_q[$];

  bit quiet;
  int fail_count;
  int requests_sent;
  int ready_hold;
  int stuck_cycles;

  three_wire_rtc_serial_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rtcsm_pkg::rtcsm_res_t pins(logic ce, logic sck, logic dout, logic drv,
                                                 logic busy, logic done);
    rtcsm_pkg::rtcsm_res_t r;
    r.ce_pin    = ce;
    r.sclk_pin  = sck;
    r.dat_out   = dout;
    r.dat_drive = drv;
    r.read_data = rx_bytes;
    r.busy_res  = busy;
    r.done_res  = done;
    return r;
  endfunction

  function automatic rtcsm_pkg::rtcsm_res_t read_low(logic din);
    shifter   = {din, shifter[7:1]};
    seq_phase = SEQ_RLOW;
    return pins(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
  endfunction

  function automatic rtcsm_pkg::rtcsm_res_t write_low();
    seq_phase = SEQ_WLOW;
    return pins(1'b1, 1'b0, shifter[0], 1'b1, 1'b1, 1'b0);
  endfunction

  function automatic rtcsm_pkg::rtcsm_res_t bus_tick(rtcsm_pkg::rtcsm_in_t it);
    rtcsm_pkg::rtcsm_res_t r;
    logic       was_read;
    int         n_bytes;
    n_bytes = cur_mode[rtcsm_pkg::MODE_BURST_BIT] ? rtcsm_pkg::BURST_N : 1;
    case (seq_phase)
      SEQ_WLOW: begin
        seq_phase = SEQ_WHIGH;
        r = pins(1'b1, 1'b1, shifter[0], 1'b1, 1'b1, 1'b0);
      end
      SEQ_RLOW: begin
        seq_phase = SEQ_RHIGH;
        r = pins(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      end
      SEQ_WHIGH, SEQ_RHIGH: begin
        was_read = (seq_phase == SEQ_RHIGH);
        if (!was_read) shifter = shifter >> 1;
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt != 3'd0) begin
          r = was_read ? read_low(it.dat_in) : write_low();
        end else begin
          if (was_read && byte_cnt >= 4'd1)
            rx_bytes |= 64'(shifter) << (8 * (int'(byte_cnt) - 1));
          byte_cnt = byte_cnt + 4'd1;
          if (int'(byte_cnt) > n_bytes) begin
            seq_phase = SEQ_IDLE;
            r = pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
          end else if (cur_mode[rtcsm_pkg::MODE_READ_BIT]) begin
            shifter = 8'd0;
            r = read_low(it.dat_in);
          end else begin
            shifter = tx_bytes[8 * (int'(byte_cnt) - 1) +: 8];
            r = write_low();
          end
        end
      end
      default: begin
        seq_phase = SEQ_IDLE;
        if (it.start_req) begin
          cur_mode = it.mode;
          tx_bytes = it.write_data;
          if (it.mode[rtcsm_pkg::MODE_READ_BIT]) rx_bytes = 64'd0;
          shifter  = (it.mode[rtcsm_pkg::MODE_BURST_BIT] ? burst_cmd : it.command_byte)
                     | {7'd0, it.mode[rtcsm_pkg::MODE_READ_BIT]};
          bit_cnt  = 3'd0;
          byte_cnt = 4'd0;
          r = write_low();
        end else begin
          r = pins(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_tick(rtcsm_pkg::rtcsm_in_t it);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, it.dat_in, it.write_data, it.command_byte, it.mode, it.start_req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pin_expect_q.push_back(bus_tick(it));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_idle_ticks(int n);
    rtcsm_pkg::rtcsm_in_t it;
    repeat (n) begin
      it.start_req    = 1'b0;
      it.mode         = 2'($urandom_range(0, 3));
      it.command_byte = 8'($urandom);
      it.write_data   = {$urandom, $urandom};
      it.dat_in       = 1'($urandom_range(0, 1));
      send_tick(it);
    end
  endtask

  task automatic run_transfer(logic [1:0] mode, logic [7:0] cmd, logic [63:0] wdata,
                              din_src_t din_src, busy_fill_t fill);
    rtcsm_pkg::rtcsm_in_t it;
    it.start_req    = 1'b1;
    it.mode         = mode;
    it.command_byte = cmd;
    it.write_data   = wdata;
    it.dat_in       = (din_src == DIN_RANDOM) ? 1'($urandom_range(0, 1)) : (din_src == DIN_HIGH);
    send_tick(it);
    while (seq_phase != SEQ_IDLE) begin
      it.dat_in = (din_src == DIN_RANDOM) ? 1'($urandom_range(0, 1)) : (din_src == DIN_HIGH);
      case (fill)
        FILL_IDLE:  it.start_req = 1'b0;
        FILL_START: it.start_req = 1'b1;
        default: begin
          it.start_req    = 1'($urandom_range(0, 1));
          it.mode         = 2'($urandom_range(0, 3));
          it.command_byte = 8'($urandom);
          it.write_data   = {$urandom, $urandom};
        end
      endcase
      send_tick(it);
    end
  endtask

  task automatic drain_results(int settle);
    s_tvalid <= 1'b0;
    while (pin_expect_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_burst_command(logic [7:0] value);
    drain_results(4);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    burst_cmd = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic test_single_transfers();
    run_transfer(MODE_SINGLE_WRITE, 8'h00, '1, DIN_LOW, FILL_IDLE);
    send_idle_ticks(2);
    run_transfer(MODE_SINGLE_READ, 8'h80, 64'd0, DIN_HIGH, FILL_START);
    run_transfer(MODE_SINGLE_WRITE, 8'hff, 64'hffff_ffff_ffff_ff00, DIN_HIGH, FILL_RANDOM);
    run_transfer(MODE_SINGLE_READ, 8'hff, '1, DIN_LOW, FILL_IDLE);
    run_transfer(MODE_SINGLE_READ, 8'($urandom), {$urandom, $urandom}, DIN_RANDOM, FILL_RANDOM);
    send_idle_ticks(3);
  endtask

  task automatic test_burst_transfers();
    run_transfer(MODE_BURST_WRITE, 8'h00, 64'h0123_4567_89ab_cdef, DIN_HIGH, FILL_START);
    run_transfer(MODE_BURST_READ, 8'h00, 64'd0, DIN_RANDOM, FILL_RANDOM);
    run_transfer(MODE_BURST_READ, 8'hff, '1, DIN_HIGH, FILL_IDLE);
    send_idle_ticks(2);
  endtask

  task automatic test_burst_command();
    set_burst_command(8'h00);
    run_transfer(MODE_BURST_READ, 8'hff, '1, DIN_LOW, FILL_IDLE);
    run_transfer(MODE_BURST_WRITE, 8'hff, '1, DIN_HIGH, FILL_RANDOM);
    set_burst_command(8'hff);
    run_transfer(MODE_BURST_WRITE, 8'h00, 64'd0, DIN_LOW, FILL_START);
    run_transfer(MODE_BURST_READ, 8'h00, 64'd0, DIN_RANDOM, FILL_IDLE);
  endtask

  task automatic test_random_traffic();
    int first;
    first = requests_sent;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      if (requests_sent - first > (RANDOM_REQUESTS * 3) / 4) quiet = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       set_burst_command(8'h00);
          1:       set_burst_command(8'hff);
          default: set_burst_command(8'($urandom));
        endcase
      end
      send_idle_ticks($urandom_range(0, 3));
      run_transfer(2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom},
                   DIN_RANDOM, busy_fill_t'($urandom_range(0, 2)));
    end
  endtask

  always @(negedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (!m_tready) begin
      m_tready <= 1'b1;
      ready_hold = $urandom_range(3, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      ready_hold = $urandom_range(0, 18);
    end
  end

  always @(posedge clk) begin
    rtcsm_pkg::rtcsm_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pin_expect_q.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pin_expect_q.pop_front();
        check_field("ce_pin", want.ce_pin, m_tdata[rtcsm_pkg::OUT_CE_BIT]);
        check_field("sclk_pin", want.sclk_pin, m_tdata[rtcsm_pkg::OUT_SCLK_BIT]);
        check_field("dat_out", want.dat_out, m_tdata[rtcsm_pkg::OUT_DOUT_BIT]);
        check_field("dat_drive", want.dat_drive, m_tdata[rtcsm_pkg::OUT_DRIVE_BIT]);
        check_field("read_data", want.read_data, m_tdata[rtcsm_pkg::OUT_RDATA_LO +: 64]);
        check_field("busy_res", want.busy_res, m_tdata[rtcsm_pkg::OUT_BUSY_BIT]);
        check_field("done_res", want.done_res, m_tdata[rtcsm_pkg::OUT_DONE_BIT]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 8'd0;
    quiet         = 1'b0;
    fail_count    = 0;
    requests_sent = 0;
    ready_hold    = 0;
    stuck_cycles  = 0;
    seq_phase     = SEQ_IDLE;
    burst_cmd     = rtcsm_pkg::BURST_CMD_RESET;
    shifter       = 8'd0;
    bit_cnt       = 3'd0;
    byte_cnt      = 4'd0;
    cur_mode      = MODE_SINGLE_WRITE;
    tx_bytes      = 64'd0;
    rx_bytes      = 64'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_transfers();
    test_burst_transfers();
    test_burst_command();
    test_random_traffic();
    drain_results(10);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* three_wire_rtc_serial_master.f */
rtl/rtcsm_pkg.sv
rtl/rtcsm_seq.sv
rtl/three_wire_rtc_serial_master.sv
rtl/rtcsm_checker.sv
sim/three_wire_rtc_serial_master_tb.sv
